### hw/rtl/lfu_pkg.sv
// shared constants and types for the lfu cache table
`default_nettype none

package lfu_pkg;

    // default sizes of the cache
    localparam int CAPACITY_DEF   = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;
    localparam int FREQ_BITS_DEF  = 16;

    // configuration port
    localparam int CFG_W      = 5;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [CFG_W-1:0] CAPACITY_RESET = 5'd16;
    // register index taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    // action codes
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_SET = 1'b1;

    // controller states
    typedef enum logic [0:0] {
        S_IDLE,
        S_LOOK
    } t_state;

    // update command broadcast to every cell
    typedef struct packed {
        logic apply_hit;  // matched cell moves to front, count rises unless saturated
        logic set_value;  // matched cell takes the new value
        logic insert;     // a new key is written into the fill cell
        logic evict;      // the insert first removes the victim
    } t_cell_cmd;

endpackage

`default_nettype wire

### hw/rtl/lfu_cell.sv
// one cache entry with its key compare and its stage of the victim chain
`default_nettype none

module lfu_cell #(
    parameter int CAPACITY   = lfu_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = lfu_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lfu_pkg::VALUE_BITS_DEF,
    parameter int FREQ_BITS  = lfu_pkg::FREQ_BITS_DEF,
    parameter int CELL_IDX   = 0
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cmp,
    input  wire  [KEY_BITS-1:0]           i_key,
    input  wire  [VALUE_BITS-1:0]         i_value,
    input  wire  lfu_pkg::t_cell_cmd      i_cmd,
    input  wire  [$clog2(CAPACITY)-1:0]   i_thr,
    input  wire                           i_kill,
    input  wire                           i_fill,
    input  wire                           i_cand_valid,
    input  wire  [FREQ_BITS-1:0]          i_cand_freq,
    input  wire  [$clog2(CAPACITY)-1:0]   i_cand_rank,
    input  wire  [$clog2(CAPACITY)-1:0]   i_cand_idx,
    input  wire  [KEY_BITS-1:0]           i_cand_key,
    input  wire  [VALUE_BITS-1:0]         i_cand_value,
    output logic                          o_valid,
    output logic                          o_match,
    output logic [VALUE_BITS-1:0]         o_value,
    output logic [$clog2(CAPACITY)-1:0]   o_rank,
    output logic                          o_cand_valid,
    output logic [FREQ_BITS-1:0]          o_cand_freq,
    output logic [$clog2(CAPACITY)-1:0]   o_cand_rank,
    output logic [$clog2(CAPACITY)-1:0]   o_cand_idx,
    output logic [KEY_BITS-1:0]           o_cand_key,
    output logic [VALUE_BITS-1:0]         o_cand_value
);
    import lfu_pkg::*;

    localparam int RANK_W = $clog2(CAPACITY);

    logic                  r_valid, n_valid;
    logic                  r_match, n_match;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [VALUE_BITS-1:0] r_value, n_value;
    logic [FREQ_BITS-1:0]  r_freq, n_freq;
    logic [RANK_W-1:0]     r_rank, n_rank;

    logic                  r_cand_valid;
    logic [FREQ_BITS-1:0]  r_cand_freq;
    logic [RANK_W-1:0]     r_cand_rank;
    logic [RANK_W-1:0]     r_cand_idx;
    logic [KEY_BITS-1:0]   r_cand_key;
    logic [VALUE_BITS-1:0] r_cand_value;
    logic                  own_better;

    // key compare, held until the next word comes in
    always_comb begin
        n_match = r_match;
        if (i_cmp) begin
            n_match = r_valid && (r_key == i_key);
        end
    end

    // entry update from the broadcast command
    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_value = r_value;
        n_freq  = r_freq;
        n_rank  = r_rank;
        if (i_cmd.apply_hit) begin
            if (r_match) begin
                n_rank = '0;
                if (r_freq != '1) begin
                    n_freq = r_freq + 1'b1;
                end
                if (i_cmd.set_value) begin
                    n_value = i_value;
                end
            end else if (r_valid && (r_rank < i_thr)) begin
                n_rank = r_rank + 1'b1;
            end
        end else if (i_cmd.insert) begin
            if (i_fill) begin
                n_valid = 1'b1;
                n_key   = i_key;
                n_value = i_value;
                n_freq  = FREQ_BITS'(1);
                n_rank  = '0;
            end else if (i_kill) begin
                n_valid = 1'b0;
            end else if (r_valid && (!i_cmd.evict || (r_rank < i_thr))) begin
                n_rank = r_rank + 1'b1;
            end
        end
    end

    // victim chain: keep the lower count, or the older entry on a tie
    always_comb begin
        own_better = r_valid && (!i_cand_valid || (r_freq < i_cand_freq) ||
                     ((r_freq == i_cand_freq) && (r_rank > i_cand_rank)));
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_match      <= 1'b0;
            r_cand_valid <= 1'b0;
        end else begin
            r_valid      <= n_valid;
            r_match      <= n_match;
            r_cand_valid <= own_better | i_cand_valid;
        end
    end

    // entry payload and chain payload
    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
        r_freq  <= n_freq;
        r_rank  <= n_rank;
        if (own_better) begin
            r_cand_freq  <= r_freq;
            r_cand_rank  <= r_rank;
            r_cand_idx   <= RANK_W'(CELL_IDX);
            r_cand_key   <= r_key;
            r_cand_value <= r_value;
        end else begin
            r_cand_freq  <= i_cand_freq;
            r_cand_rank  <= i_cand_rank;
            r_cand_idx   <= i_cand_idx;
            r_cand_key   <= i_cand_key;
            r_cand_value <= i_cand_value;
        end
    end

    assign o_valid      = r_valid;
    assign o_match      = r_match;
    assign o_value      = r_value;
    assign o_rank       = r_rank;
    assign o_cand_valid = r_cand_valid;
    assign o_cand_freq  = r_cand_freq;
    assign o_cand_rank  = r_cand_rank;
    assign o_cand_idx   = r_cand_idx;
    assign o_cand_key   = r_cand_key;
    assign o_cand_value = r_cand_value;

endmodule

`default_nettype wire

### hw/rtl/lfu_cache_table.sv
// top level of the lfu cache table: cell row, controller and ports
// hits, get misses and inserts into free room: the input word and match bits are registered and
//   the result register takes the decision made in S_LOOK; an evicting set waits there until the
//   victim chain has run through all CAPACITY cells since the last change
// one word in flight at a time; the next word is taken while the result waits in its register
// reset is synchronous active low: all entries invalid, capacity back to 16
`default_nettype none

module lfu_cache_table #(
    parameter int CAPACITY   = lfu_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = lfu_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lfu_pkg::VALUE_BITS_DEF,
    parameter int FREQ_BITS  = lfu_pkg::FREQ_BITS_DEF
) (
    input  wire                                        i_clk,
    input  wire                                        i_rst_n,
    // input stream
    input  wire                                        s_axis_tvalid,
    output logic                                       s_axis_tready,
    // key, write_value
    input  wire  [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0]   s_axis_tdata,
    // action
    input  wire  [0:0]                                 s_axis_tuser,
    // result stream
    output logic                                       m_axis_tvalid,
    input  wire                                        m_axis_tready,
    // read_value, evicted_key, evicted_value
    output logic [((2*VALUE_BITS+KEY_BITS+7)/8)*8-1:0] m_axis_tdata,
    // hit, evicted
    output logic [1:0]                                 m_axis_tuser,
    // configuration
    input  wire                                        psel,
    input  wire                                        penable,
    input  wire                                        pwrite,
    input  wire  [lfu_pkg::APB_ADDR_W-1:0]             paddr,
    input  wire  [lfu_pkg::APB_DATA_W-1:0]             pwdata,
    output logic [lfu_pkg::APB_DATA_W-1:0]             prdata,
    output logic                                       pready
);
    import lfu_pkg::*;

    localparam int RANK_W    = $clog2(CAPACITY);
    localparam int HELD_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W     = (HELD_W > CFG_W) ? HELD_W : CFG_W;
    localparam int M_TDATA_W = ((2*VALUE_BITS+KEY_BITS+7)/8)*8;

    // configuration register
    logic [CFG_W-1:0] r_capacity;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DATA_W'(r_capacity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (cfg_wr) begin
            r_capacity <= pwdata[CFG_W-1:0];
        end
    end

    // input word
    logic                  accept;
    logic                  r_act;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_wval;

    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act  <= s_axis_tuser[0];
            r_key  <= s_axis_tdata[KEY_BITS-1:0];
            r_wval <= s_axis_tdata[KEY_BITS +: VALUE_BITS];
        end
    end

    // cell row and victim chain
    t_cell_cmd             cmd;
    logic [RANK_W-1:0]     thr;
    logic [CAPACITY-1:0]   kill_vec;
    logic [CAPACITY-1:0]   fill_vec;
    logic [CAPACITY-1:0]   valid_vec;
    logic [CAPACITY-1:0]   match_vec;
    logic [VALUE_BITS-1:0] value_arr [CAPACITY];
    logic [RANK_W-1:0]     rank_arr  [CAPACITY];

    logic                  ch_valid [CAPACITY+1];
    logic [FREQ_BITS-1:0]  ch_freq  [CAPACITY+1];
    logic [RANK_W-1:0]     ch_rank  [CAPACITY+1];
    logic [RANK_W-1:0]     ch_idx   [CAPACITY+1];
    logic [KEY_BITS-1:0]   ch_key   [CAPACITY+1];
    logic [VALUE_BITS-1:0] ch_value [CAPACITY+1];

    assign ch_valid[0] = 1'b0;
    assign ch_freq[0]  = '0;
    assign ch_rank[0]  = '0;
    assign ch_idx[0]   = '0;
    assign ch_key[0]   = '0;
    assign ch_value[0] = '0;

    // the key port carries the incoming key on accept, the latched key otherwise
    logic [KEY_BITS-1:0] cell_key;
    assign cell_key = accept ? s_axis_tdata[KEY_BITS-1:0] : r_key;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        lfu_cell #(
            .CAPACITY   (CAPACITY),
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS),
            .FREQ_BITS  (FREQ_BITS),
            .CELL_IDX   (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmp        (accept),
            .i_key        (cell_key),
            .i_value      (r_wval),
            .i_cmd        (cmd),
            .i_thr        (thr),
            .i_kill       (kill_vec[g]),
            .i_fill       (fill_vec[g]),
            .i_cand_valid (ch_valid[g]),
            .i_cand_freq  (ch_freq[g]),
            .i_cand_rank  (ch_rank[g]),
            .i_cand_idx   (ch_idx[g]),
            .i_cand_key   (ch_key[g]),
            .i_cand_value (ch_value[g]),
            .o_valid      (valid_vec[g]),
            .o_match      (match_vec[g]),
            .o_value      (value_arr[g]),
            .o_rank       (rank_arr[g]),
            .o_cand_valid (ch_valid[g+1]),
            .o_cand_freq  (ch_freq[g+1]),
            .o_cand_rank  (ch_rank[g+1]),
            .o_cand_idx   (ch_idx[g+1]),
            .o_cand_key   (ch_key[g+1]),
            .o_cand_value (ch_value[g+1])
        );
    end

    // hit lookup from the registered match bits
    logic                  hit;
    logic [VALUE_BITS-1:0] hit_value;
    logic [RANK_W-1:0]     hit_rank;

    always_comb begin
        hit       = |match_vec;
        hit_value = '0;
        hit_rank  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            hit_value = hit_value | (value_arr[i] & {VALUE_BITS{match_vec[i]}});
            hit_rank  = hit_rank  | (rank_arr[i]  & {RANK_W{match_vec[i]}});
        end
    end

    // capacity clamp and fill level
    logic [HELD_W-1:0] r_held;
    logic [CMP_W-1:0]  cap_ext;
    logic [CMP_W-1:0]  cap_lim;
    logic              need_evict;

    always_comb begin
        cap_ext = CMP_W'(r_capacity);
        if (cap_ext == '0) begin
            cap_lim = CMP_W'(1);
        end else if (cap_ext > CMP_W'(CAPACITY)) begin
            cap_lim = CMP_W'(CAPACITY);
        end else begin
            cap_lim = cap_ext;
        end
        need_evict = CMP_W'(r_held) >= cap_lim;
    end

    // settle count of the victim chain since the last entry change
    logic [HELD_W-1:0] r_settle;
    logic              victim_ready;
    assign victim_ready = (r_settle == HELD_W'(CAPACITY));

    // decision for the word in flight
    t_state r_state, n_state;
    logic   r_out_valid;
    logic   set_miss;
    logic   out_free;
    logic   done;
    logic   evict_now;
    logic [CAPACITY-1:0] free_vec;

    always_comb begin
        set_miss  = (r_act == ACT_SET) && !hit;
        out_free  = !r_out_valid || m_axis_tready;
        done      = (r_state == S_LOOK) && out_free &&
                    !(set_miss && need_evict && !victim_ready);
        evict_now = set_miss && need_evict && ch_valid[CAPACITY];
        for (int i = 0; i < CAPACITY; i++) begin
            kill_vec[i] = evict_now && (ch_idx[CAPACITY] == RANK_W'(i));
        end
        // lowest free slot after the victim leaves
        free_vec = ~valid_vec | kill_vec;
        fill_vec = (free_vec & (~free_vec + 1'b1)) & {CAPACITY{done && set_miss}};
        cmd.apply_hit = done && hit;
        cmd.set_value = (r_act == ACT_SET);
        cmd.insert    = done && set_miss;
        cmd.evict     = evict_now;
        thr = hit ? hit_rank : ch_rank[CAPACITY];
    end

    // fill level and chain settle counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_settle <= '0;
        end else begin
            if (cmd.insert && !evict_now) begin
                r_held <= r_held + 1'b1;
            end
            if (cmd.apply_hit || cmd.insert) begin
                r_settle <= '0;
            end else if (!victim_ready) begin
                r_settle <= r_settle + 1'b1;
            end
        end
    end

    // controller next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // controller outputs
    always_comb begin
        case (r_state)
            S_IDLE:  s_axis_tready = 1'b1;
            S_LOOK:  s_axis_tready = 1'b0;
            default: s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // result register
    logic                  r_out_hit;
    logic                  r_out_evicted;
    logic [VALUE_BITS-1:0] r_out_rval;
    logic [KEY_BITS-1:0]   r_out_evkey;
    logic [VALUE_BITS-1:0] r_out_evval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_hit     <= hit;
            r_out_rval    <= (hit && (r_act == ACT_GET)) ? hit_value : '0;
            r_out_evicted <= evict_now;
            r_out_evkey   <= evict_now ? ch_key[CAPACITY] : '0;
            r_out_evval   <= evict_now ? ch_value[CAPACITY] : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = {r_out_evicted, r_out_hit};
    assign m_axis_tdata  = M_TDATA_W'({r_out_evval, r_out_evkey, r_out_rval});

endmodule

`default_nettype wire

### hw/rtl/lfu_chk.sv
// port checker for the lfu cache table, bound to the top level
`default_nettype none

module lfu_chk #(
    parameter int KEY_BITS   = lfu_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lfu_pkg::VALUE_BITS_DEF
) (
    input wire                                        i_clk,
    input wire                                        i_rst_n,
    input wire                                        m_axis_tvalid,
    input wire                                        m_axis_tready,
    input wire [((2*VALUE_BITS+KEY_BITS+7)/8)*8-1:0]  m_axis_tdata,
    input wire [1:0]                                  m_axis_tuser
);
    import lfu_pkg::*;

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its data
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("hit and eviction in one result");

    // read value is zero without a hit
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[VALUE_BITS-1:0] == '0)
        else $error("read value set on a miss");

    // evicted key and value are zero without an eviction
    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[1] |->
            m_axis_tdata[VALUE_BITS +: (KEY_BITS+VALUE_BITS)] == '0)
        else $error("evicted fields set without an eviction");

endmodule

bind lfu_cache_table lfu_chk #(
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
) u_lfu_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
